FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro expects i_clk and i_rst_n to exist in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, ignored while reset is asserted.
`define PFP_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define PFP_ASSERT_IMP(lbl, ante, cons, msg) \
    `PFP_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PFP_ASSERT_NXT(lbl, ante, cons, msg) \
    `PFP_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: src/pfp_pkg.sv
// Package for the PCM frame FIFO and PWM player: sizes, codes, item types and
// the sample conversion functions. No dependencies.
package pfp_pkg;

    // Sample FIFO.
    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W     = 9;

    // Command queue between the front and the back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd3;

    // Operation codes.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [7:0] SILENCE    = 8'd127;
    localparam logic [3:0] VOLUME_MAX = 4'd8;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [7:0] byte_d;
        logic [3:0] frame_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        duty;
        logic              underrun;
        logic              push_accepted;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

    // One decided item on its way to the back.
    typedef struct packed {
        logic [1:0]        kind;
        logic              play;
        logic              underrun;
        logic              push_accepted;
        logic [FILL_W-1:0] fill_level;
        logic [2:0]        shift;
        logic [7:0]        sample;
    } t_cmd;

    // Sample store access from the front.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Turns one PCM frame into an unsigned 8-bit sample.
    function automatic logic [7:0] convert_frame(input t_in_item it, input logic wide,
                                                 input logic stereo);
        logic [3:0]  need;
        logic [8:0]  sum8;
        logic [15:0] l16;
        logic [15:0] r16;
        logic [16:0] sum16;
        logic [16:0] adj16;
        logic [15:0] mix16;
        logic [7:0]  res;
        need  = wide ? (stereo ? 4'd4 : 4'd2) : (stereo ? 4'd2 : 4'd1);
        sum8  = {1'b0, it.byte_a} + {1'b0, it.byte_b};
        l16   = {it.byte_b, it.byte_a};
        r16   = {it.byte_d, it.byte_c};
        sum16 = {l16[15], l16} + {r16[15], r16};
        // Adding one to a negative sum before the shift rounds toward zero.
        adj16 = sum16 + {16'd0, sum16[16]};
        mix16 = stereo ? adj16[16:1] : l16;
        if (it.frame_bytes < need) begin
            res = SILENCE;
        end else if (!wide) begin
            res = stereo ? sum8[8:1] : it.byte_a;
        end else begin
            // Upper byte with the sign flipped is (mix >>> 8) + 128.
            res = {~mix16[15], mix16[14:8]};
        end
        return res;
    endfunction

    // Attenuation shift for a volume level, levels above the maximum saturate.
    function automatic logic [2:0] atten_shift(input logic [3:0] level);
        logic [3:0] lvl;
        logic [3:0] diff;
        lvl  = (level > VOLUME_MAX) ? VOLUME_MAX : level;
        diff = VOLUME_MAX - lvl;
        return diff[3:1];
    endfunction

    // Attenuates a sample around the midpoint by an arithmetic shift.
    function automatic logic [7:0] play_duty(input logic [7:0] sample, input logic [2:0] shift);
        logic signed [8:0] centered;
        logic signed [8:0] scaled;
        logic signed [8:0] biased;
        centered = $signed({1'b0, sample}) - 9'sd128;
        scaled   = centered >>> shift;
        biased   = scaled + 9'sd128;
        return biased[7:0];
    endfunction

endpackage

FILE: src/pfp_ifs.sv
// Handshake channel interfaces of the PCM frame FIFO and PWM player.
// Depends on pfp_pkg for the payload types and configuration widths.
interface pfp_in_if import pfp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pfp_out_if import pfp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pfp_cfg_if import pfp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/pfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/pfp_front.sv
// Front of the player: configuration registers, frame conversion, FIFO
// bookkeeping and sample store access. Depends on pfp_pkg and pfp_ifs.
module pfp_front import pfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfp_in_if.sink            i_in,
    pfp_cfg_if.sink           i_cfg,
    input  logic [QCNT_W-1:0] i_q_level,
    input  logic [7:0]        i_ram_rdata,
    output t_ram_req          o_ram,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);
    logic              r_wide;
    logic              r_stereo;
    logic [3:0]        r_volume;
    logic              r_enable;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_wr, n_wr;
    logic [ADDR_W-1:0] r_rd, n_rd;
    logic              r_s1_valid;
    logic              r_s1_pop, n_s1_pop;
    t_cmd              r_s1_cmd, n_s1_cmd;

    logic              in_fire;
    logic              cfg_fire;
    logic              can_store;
    logic [QCNT_W:0]   pending;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    // Every accepted item passes the read stage before it lands in the queue, so
    // the item in the read stage counts against the free space.
    assign pending    = {1'b0, i_q_level} + (QCNT_W + 1)'(r_s1_valid);
    assign i_in.ready = pending < (QCNT_W + 1)'(QDEPTH);
    assign in_fire    = i_in.valid && i_in.ready;

    assign can_store = (i_in.payload.frame_bytes != 4'd0) &&
                       (r_count < CNT_W'(FIFO_DEPTH));

    always_comb begin
        n_count     = r_count;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_s1_pop    = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_wr;
        o_ram.wdata = convert_frame(i_in.payload, r_wide, r_stereo);
        o_ram.raddr = r_rd;

        n_s1_cmd               = '0;
        n_s1_cmd.kind          = i_in.payload.operation;
        n_s1_cmd.shift         = atten_shift(r_volume);
        n_s1_cmd.sample        = SILENCE;

        if (in_fire) begin
            case (i_in.payload.operation)
                OP_PUSH: begin
                    if (can_store) begin
                        o_ram.we               = 1'b1;
                        n_wr                   = (r_wr == ADDR_W'(FIFO_DEPTH - 1)) ?
                                                 '0 : r_wr + 1'b1;
                        n_count                = r_count + 1'b1;
                        n_s1_cmd.push_accepted = 1'b1;
                    end
                end
                OP_TICK: begin
                    n_s1_cmd.play = r_enable;
                    if (r_enable) begin
                        if (r_count != '0) begin
                            n_s1_pop = 1'b1;
                            n_rd     = (r_rd == ADDR_W'(FIFO_DEPTH - 1)) ?
                                       '0 : r_rd + 1'b1;
                            n_count  = r_count - 1'b1;
                        end else begin
                            n_s1_cmd.underrun = 1'b1;
                        end
                    end
                end
                OP_FLUSH: begin
                    n_count = '0;
                    n_wr    = '0;
                    n_rd    = '0;
                end
                default: begin
                end
            endcase
        end

        n_s1_cmd.fill_level = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide     <= 1'b0;
            r_stereo   <= 1'b0;
            r_volume   <= VOLUME_MAX;
            r_enable   <= 1'b0;
            r_count    <= '0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            r_s1_valid <= in_fire;
            if (cfg_fire) begin
                case (i_cfg.index)
                    CFG_WIDE:   r_wide   <= i_cfg.data[0];
                    CFG_STEREO: r_stereo <= i_cfg.data[0];
                    CFG_VOLUME: r_volume <= i_cfg.data;
                    CFG_ENABLE: r_enable <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pop <= n_s1_pop;
        r_s1_cmd <= n_s1_cmd;
    end

    // The store's read data for the popped slot arrives with the read stage.
    always_comb begin
        o_q_cmd        = r_s1_cmd;
        o_q_cmd.sample = r_s1_pop ? i_ram_rdata : SILENCE;
    end
    assign o_q_push = r_s1_valid;
endmodule

FILE: src/pfp_cmd_queue.sv
// Short queue of decided items between the front and the back.
// Depends on pfp_pkg.
module pfp_cmd_queue import pfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cmd              i_cmd,
    input  logic              i_pop,
    output logic              o_valid,
    output t_cmd              o_cmd,
    output logic [QCNT_W-1:0] o_level
);
    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_cmd;
        end
    end

    assign o_valid = r_level != '0;
    assign o_cmd   = r_slot[r_head];
    assign o_level = r_level;
endmodule

FILE: src/pfp_back.sv
// Back of the player: computes the PWM duty and holds the result register.
// Depends on pfp_pkg and pfp_ifs.
module pfp_back import pfp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_cmd     i_q_cmd,
    output logic     o_q_pop,
    pfp_out_if.source o_out
);
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_out.kind          = i_q_cmd.kind;
        n_out.duty          = i_q_cmd.play ? play_duty(i_q_cmd.sample, i_q_cmd.shift) : SILENCE;
        n_out.underrun      = i_q_cmd.underrun;
        n_out.push_accepted = i_q_cmd.push_accepted;
        n_out.fill_level    = i_q_cmd.fill_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
endmodule

FILE: src/pcm_frame_fifo_pwm_player_core.sv
// Top level of the PCM frame FIFO and PWM player.
// Depends on pfp_pkg, pfp_ifs, pfp_ram, pfp_front, pfp_cmd_queue and pfp_back.
//
// Usage:
// Items enter on i_in (valid/ready). Operation 0 pushes one PCM frame, which is
// converted to an 8-bit sample and stored in a 256-entry sample FIFO; operation
// 1 is a playback tick that pops one sample and returns the attenuated PWM
// duty; operation 2 flushes the FIFO. Every item gives exactly one result on
// o_out (valid/ready), in order. Registers are written on i_cfg, which is
// always ready; write them only while no item is in flight.
// A result passes the read stage, the command queue and the result register
// before it appears on o_out. Throughput is one item per cycle while the
// receiver keeps o_out ready, set by the single write port and the single read
// port of the sample store, each used at most once per item.
// Reset clears the FIFO pointers and fill count, the command queue and the
// result register, and loads the registers with 8-bit mono, full volume and
// output disabled. The sample store itself needs no clearing pass.
// When the receiver stalls, the result register holds and the four-entry
// command queue absorbs items already accepted; i_in.ready drops once the
// queue and the read stage together would fill it.
module pcm_frame_fifo_pwm_player_core import pfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfp_in_if.sink    i_in,
    pfp_cfg_if.sink   i_cfg,
    pfp_out_if.source o_out
);
    // The front decides every item at acceptance: it updates the pointers and
    // the fill count, writes pushed samples and starts the read of a popped
    // sample. The read data joins the item in the following cycle as it enters the
    // command queue.
    t_ram_req          ram_req;
    logic [7:0]        ram_rdata;
    logic              q_push;
    t_cmd              q_in_cmd;
    logic              q_valid;
    t_cmd              q_out_cmd;
    logic              q_pop;
    logic [QCNT_W-1:0] q_level;

    pfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_q_level   (q_level),
        .i_ram_rdata (ram_rdata),
        .o_ram       (ram_req),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    // Sample store. A pop reads only slots written by an earlier push, so the
    // contents after reset never reach the output.
    pfp_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Decouples the front from the result handshake.
    pfp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .o_level (q_level)
    );

    // The back applies the volume attenuation and owns the result register.
    pfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule

FILE: src/pfp_checker.sv
// Port-level checker for the PCM frame FIFO and PWM player, bound to the top.
// Depends on pfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfp_checker import pfp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);
    `PFP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "stalled result changed")
    `PFP_ASSERT_IMP(a_underrun_tick, i_out_valid && i_out_payload.underrun, (i_out_payload.kind == OP_TICK) && (i_out_payload.duty == SILENCE), "underrun outside a silent tick")
    `PFP_ASSERT_IMP(a_idle_duty, i_out_valid && (i_out_payload.kind != OP_TICK), (i_out_payload.duty == SILENCE) && !i_out_payload.underrun, "non-tick result carries a duty")
    `PFP_ASSERT_IMP(a_flush_empty, i_out_valid && (i_out_payload.kind == OP_FLUSH), (i_out_payload.fill_level == '0) && !i_out_payload.push_accepted, "flush left samples behind")
endmodule

bind pcm_frame_fifo_pwm_player_core pfp_checker u_pfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
